### rtl/core/nsl_pkg.sv
// Shared types for the nearest-site labeler.
// Holds the command codes and the control group that walks the cell chain.
// No dependencies.
package nsl_pkg;

    localparam int IDX_BITS     = 5;  // width of site_index and cell_index
    localparam int ID_CMP_BITS  = 8;  // wide enough to compare any cell id

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_ctl;

endpackage

### rtl/core/nsl_cell.sv
// One cell of the site chain: holds one site position and folds its
// squared distance into the running best of each passing query beat.
// Depends on nsl_pkg.
module nsl_cell #(
    parameter int COORD_BITS = 6,
    parameter int BEST_BITS  = 5,
    parameter int CELL_ID    = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  nsl_pkg::t_ctl                     i_ctl,
    input  logic [nsl_pkg::IDX_BITS-1:0]      i_site_index,
    input  logic [COORD_BITS-1:0]             i_x,
    input  logic [COORD_BITS-1:0]             i_y,
    input  logic [BEST_BITS-1:0]              i_best,
    input  logic [2*COORD_BITS:0]             i_best_d,
    output nsl_pkg::t_ctl                     o_ctl,
    output logic [nsl_pkg::IDX_BITS-1:0]      o_site_index,
    output logic [COORD_BITS-1:0]             o_x,
    output logic [COORD_BITS-1:0]             o_y,
    output logic [BEST_BITS-1:0]              o_best,
    output logic [2*COORD_BITS:0]             o_best_d
);
    import nsl_pkg::*;

    localparam int DIST_BITS = 2 * COORD_BITS + 1;

    logic [COORD_BITS-1:0]  r_site_x;
    logic [COORD_BITS-1:0]  r_site_y;

    logic                   w_hit;
    logic [COORD_BITS-1:0]  w_gx;
    logic [COORD_BITS-1:0]  w_gy;
    logic [DIST_BITS-1:0]   n_a_dist;
    logic                   w_closer;

    t_ctl                   r_a_ctl;
    logic [IDX_BITS-1:0]    r_a_idx;
    logic [COORD_BITS-1:0]  r_a_x;
    logic [COORD_BITS-1:0]  r_a_y;
    logic [BEST_BITS-1:0]   r_a_best;
    logic [DIST_BITS-1:0]   r_a_best_d;
    logic [DIST_BITS-1:0]   r_a_dist;

    t_ctl                   r_b_ctl;
    logic [IDX_BITS-1:0]    r_b_idx;
    logic [COORD_BITS-1:0]  r_b_x;
    logic [COORD_BITS-1:0]  r_b_y;
    logic [BEST_BITS-1:0]   r_b_best;
    logic [DIST_BITS-1:0]   r_b_best_d;
    logic [BEST_BITS-1:0]   n_b_best;
    logic [DIST_BITS-1:0]   n_b_best_d;

    assign w_hit = i_ctl.valid && (i_ctl.cmd == CMD_LOAD)
                && (ID_CMP_BITS'(i_site_index) == ID_CMP_BITS'(CELL_ID));

    // Site write happens as the load beat enters, so any query behind it sees it.
    always_ff @(posedge i_clk) begin
        if (i_advance && w_hit) begin
            r_site_x <= i_x;
            r_site_y <= i_y;
        end
    end

    always_comb begin
        w_gx     = (i_x > r_site_x) ? (i_x - r_site_x) : (r_site_x - i_x);
        w_gy     = (i_y > r_site_y) ? (i_y - r_site_y) : (r_site_y - i_y);
        n_a_dist = DIST_BITS'(w_gx) * DIST_BITS'(w_gx)
                 + DIST_BITS'(w_gy) * DIST_BITS'(w_gy);
    end

    // Stage A: distance for this cell's site.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '{valid: 1'b0, cmd: CMD_LOAD};
        end else if (i_advance) begin
            r_a_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_a_idx    <= i_site_index;
            r_a_x      <= i_x;
            r_a_y      <= i_y;
            r_a_best   <= i_best;
            r_a_best_d <= i_best_d;
            r_a_dist   <= n_a_dist;
        end
    end

    // Stage B: strict less-than keeps the lower index on a tie.
    assign w_closer = (r_a_ctl.cmd == CMD_QUERY) && (r_a_dist < r_a_best_d);

    always_comb begin
        if (w_closer) begin
            n_b_best   = BEST_BITS'(CELL_ID);
            n_b_best_d = r_a_dist;
        end else begin
            n_b_best   = r_a_best;
            n_b_best_d = r_a_best_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '{valid: 1'b0, cmd: CMD_LOAD};
        end else if (i_advance) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_b_idx    <= r_a_idx;
            r_b_x      <= r_a_x;
            r_b_y      <= r_a_y;
            r_b_best   <= n_b_best;
            r_b_best_d <= n_b_best_d;
        end
    end

    assign o_ctl        = r_b_ctl;
    assign o_site_index = r_b_idx;
    assign o_x          = r_b_x;
    assign o_y          = r_b_y;
    assign o_best       = r_b_best;
    assign o_best_d     = r_b_best_d;

endmodule

### rtl/core/nearest_site_labeler.sv
// Nearest-site labeler: brute-force Voronoi labeling over a chain of site cells.
// Top level; depends on nsl_pkg and nsl_cell.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one beat per command. A load
//   (i_command = 0) stores pos_x/pos_y as site i_site_index and gives no
//   result. A query (i_command = 1) gives one o_cell_index: the nearest
//   site by squared distance, the lowest index on ties.
//   Output channel (o_valid / i_stall) carries one beat per query.
//   Every beat walks a chain of NUM_SITES cells, two register stages per cell,
//   then an output register. The chain takes one beat per clock while it is
//   not held, so throughput is one pixel per cycle; loads and queries may be
//   freely interleaved since a load writes its cell just as it passes, in
//   order with the queries.
//   While a result sits in the output register and i_stall is high, the
//   whole chain holds and o_stall is raised; otherwise beats are accepted.
//   Reset clears the chain and output valid flags and holds o_stall high;
//   site positions are not cleared and must be loaded before they are queried.
module nearest_site_labeler #(
    parameter int NUM_SITES  = 24,
    parameter int COORD_BITS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [nsl_pkg::IDX_BITS-1:0]  i_site_index,
    input  logic [COORD_BITS-1:0]         i_pos_x,
    input  logic [COORD_BITS-1:0]         i_pos_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nsl_pkg::IDX_BITS-1:0]  o_cell_index
);
    import nsl_pkg::*;

    localparam int BEST_BITS = $clog2(NUM_SITES);
    localparam int DIST_BITS = 2 * COORD_BITS + 1;

    t_ctl                   w_ctl      [0:NUM_SITES];
    logic [IDX_BITS-1:0]    w_idx      [0:NUM_SITES];
    logic [COORD_BITS-1:0]  w_x        [0:NUM_SITES];
    logic [COORD_BITS-1:0]  w_y        [0:NUM_SITES];
    logic [BEST_BITS-1:0]   w_best     [0:NUM_SITES];
    logic [DIST_BITS-1:0]   w_best_d   [0:NUM_SITES];

    logic                   w_advance;
    logic                   r_out_valid;
    logic [IDX_BITS-1:0]    r_out_index;

    // Advance the chain unless in reset or a finished result is held by the receiver.
    assign w_advance = i_rst_n && !(r_out_valid && i_stall);
    assign o_stall   = !w_advance;

    // All-ones start distance exceeds any real distance, so cell 0 always wins.
    assign w_ctl[0]    = '{valid: i_valid, cmd: t_cmd'(i_command)};
    assign w_idx[0]    = i_site_index;
    assign w_x[0]      = i_pos_x;
    assign w_y[0]      = i_pos_y;
    assign w_best[0]   = '0;
    assign w_best_d[0] = '1;

    for (genvar g = 0; g < NUM_SITES; g++) begin : g_cell
        nsl_cell #(
            .COORD_BITS (COORD_BITS),
            .BEST_BITS  (BEST_BITS),
            .CELL_ID    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_advance    (w_advance),
            .i_ctl        (w_ctl[g]),
            .i_site_index (w_idx[g]),
            .i_x          (w_x[g]),
            .i_y          (w_y[g]),
            .i_best       (w_best[g]),
            .i_best_d     (w_best_d[g]),
            .o_ctl        (w_ctl[g+1]),
            .o_site_index (w_idx[g+1]),
            .o_x          (w_x[g+1]),
            .o_y          (w_y[g+1]),
            .o_best       (w_best[g+1]),
            .o_best_d     (w_best_d[g+1])
        );
    end

    // Drop load beats at the end of the chain; only queries produce a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_ctl[NUM_SITES].valid && (w_ctl[NUM_SITES].cmd == CMD_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_index <= IDX_BITS'(w_best[NUM_SITES]);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cell_index = r_out_index;

endmodule

### dv/nearest_site_labeler_test.sv
// Self-checking testbench for nearest_site_labeler: loads site tables, sends pixel queries
// and checks each returned cell index against a nearest-site predictor of its own.
// Depends on nsl_pkg and the nearest_site_labeler RTL.
`timescale 1ns / 100ps

module nearest_site_labeler_test;
    import nsl_pkg::*;

    localparam int NUM_SITES   = 24;
    localparam int COORD_BITS  = 6;
    localparam int LATENCY     = 2 * NUM_SITES + 1;
    localparam int RANDOM_BEATS = 1200;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        t_cmd                  cmd;
        logic [IDX_BITS-1:0]   idx;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_beat;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_command;
    logic [IDX_BITS-1:0]   i_site_index;
    logic [COORD_BITS-1:0] i_pos_x;
    logic [COORD_BITS-1:0] i_pos_y;
    logic                  o_valid;
    logic                  i_stall;
    logic [IDX_BITS-1:0]   o_cell_index;

    t_beat                 beats_to_send[$];
    logic [IDX_BITS-1:0]   expected_cells[$];
    logic [COORD_BITS-1:0] site_x_mirror[NUM_SITES];
    logic [COORD_BITS-1:0] site_y_mirror[NUM_SITES];
    int                    total_beats = 0;
    int                    n_accepted = 0;
    int                    n_fail = 0;
    int                    cycle_count = 0;
    int                    send_gap = 0;
    int                    stall_gap = 0;
    bit                    in_fire = 1'b0;

    nearest_site_labeler #(
        .NUM_SITES  (NUM_SITES),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_site_index (i_site_index),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_index (o_cell_index)
    );

    always #10 i_clk = ~i_clk;

    // Scan every site in index order; strict less-than keeps the lowest index on a tie.
    function automatic logic [IDX_BITS-1:0] nearest_site(input logic [COORD_BITS-1:0] px,
                                                         input logic [COORD_BITS-1:0] py);
        int dx, dy, d, best_d;
        logic [IDX_BITS-1:0] best;
        best = '0;
        best_d = 0;
        for (int k = 0; k < NUM_SITES; k++) begin
            dx = int'(px) - int'(site_x_mirror[k]);
            dy = int'(py) - int'(site_y_mirror[k]);
            d = dx * dx + dy * dy;
            if (k == 0 || d < best_d) begin
                best_d = d;
                best = IDX_BITS'(k);
            end
        end
        return best;
    endfunction

    // No idling in the last stretch, and every fourth window of 150 beats runs clean.
    function automatic bit idle_allowed();
        return (n_accepted + 200 < total_beats) && ((n_accepted / 150) % 4 != 3);
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord(input bit on_grid);
        int k;
        if (!on_grid)
            return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
        k = $urandom_range(0, 8);
        return (k == 8) ? COORD_BITS'((1 << COORD_BITS) - 1) : COORD_BITS'(k * 8);
    endfunction

    task automatic push_beat(input t_cmd cmd, input int idx, input int x, input int y);
        t_beat b;
        b.cmd = cmd;
        b.idx = IDX_BITS'(idx);
        b.x = COORD_BITS'(x);
        b.y = COORD_BITS'(y);
        beats_to_send.push_back(b);
    endtask

    // Input driver: advance only when the slot is empty or the last beat was taken.
    always @(negedge i_clk) begin : drive_input
        t_beat b;
        if (i_rst_n && (!i_valid || in_fire)) begin
            if (send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap = send_gap - 1;
            end else if (beats_to_send.size() > 0) begin
                b = beats_to_send.pop_front();
                i_valid <= 1'b1;
                i_command <= b.cmd;
                i_site_index <= b.idx;
                i_pos_x <= b.x;
                i_pos_y <= b.y;
                if (idle_allowed() && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 9);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure in bursts.
    always @(negedge i_clk) begin
        if (stall_gap > 0) begin
            i_stall <= 1'b1;
            stall_gap = stall_gap - 1;
        end else begin
            i_stall <= 1'b0;
            if (idle_allowed() && $urandom_range(0, 7) == 0)
                stall_gap = $urandom_range(1, 9);
        end
    end

    // Capture accepted beats into the predictor and check returned cells in order.
    always @(posedge i_clk) begin : track_and_check
        logic [IDX_BITS-1:0] want;
        in_fire = i_rst_n && i_valid && !o_stall;
        if (in_fire) begin
            n_accepted++;
            if (i_command == CMD_LOAD) begin
                // drop loads beyond the table
                if (i_site_index < NUM_SITES) begin
                    site_x_mirror[i_site_index] = i_pos_x;
                    site_y_mirror[i_site_index] = i_pos_y;
                end
            end else begin
                expected_cells.push_back(nearest_site(i_pos_x, i_pos_y));
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cells.size() == 0) begin
                $error("cell_index: expected none, actual %0d", o_cell_index);
                n_fail++;
            end else begin
                want = expected_cells.pop_front();
                if (o_cell_index !== want) begin
                    $error("cell_index: expected %0d, actual %0d", want, o_cell_index);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** nearest_site_labeler: FAILED **");
            $finish;
        end
    end

    initial begin
        int r;
        bit on_grid;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_command = CMD_LOAD;
        i_site_index = '0;
        i_pos_x = '0;
        i_pos_y = '0;

        // Directed: corners, a duplicate site for a tie, an equidistant pair, then the rest.
        push_beat(CMD_LOAD, 0, 0, 0);
        push_beat(CMD_LOAD, 1, 63, 63);
        push_beat(CMD_LOAD, 2, 0, 63);
        push_beat(CMD_LOAD, 3, 63, 0);
        push_beat(CMD_LOAD, 4, 32, 32);
        push_beat(CMD_LOAD, 5, 32, 32);
        push_beat(CMD_LOAD, 6, 10, 20);
        push_beat(CMD_LOAD, 7, 20, 20);
        for (int k = 8; k < NUM_SITES; k++)
            push_beat(CMD_LOAD, k, $urandom_range(8, 56), $urandom_range(8, 56));
        // out-of-range loads must leave the table alone
        push_beat(CMD_LOAD, NUM_SITES, 40, 40);
        push_beat(CMD_LOAD, 31, 5, 5);
        push_beat(CMD_QUERY, 31, 0, 0);
        push_beat(CMD_QUERY, 0, 63, 63);
        push_beat(CMD_QUERY, 21, 0, 63);
        push_beat(CMD_QUERY, 10, 63, 0);
        push_beat(CMD_QUERY, 4, 32, 32);
        push_beat(CMD_QUERY, 15, 15, 20);
        push_beat(CMD_QUERY, 24, 40, 40);
        push_beat(CMD_QUERY, 7, 5, 5);

        // Random: mostly queries; odd windows snap to a coarse grid so ties are common.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            r = $urandom_range(0, 99);
            on_grid = ((n / 200) % 2) == 1;
            if (r < 17)
                push_beat(CMD_LOAD, $urandom_range(0, NUM_SITES - 1),
                          rand_coord(on_grid), rand_coord(on_grid));
            else if (r < 20)
                push_beat(CMD_LOAD, $urandom_range(NUM_SITES, 31),
                          rand_coord(1'b0), rand_coord(1'b0));
            else
                push_beat(CMD_QUERY, $urandom_range(0, 31),
                          rand_coord(on_grid), rand_coord(on_grid));
        end
        total_beats = beats_to_send.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_accepted == total_beats);
        while (expected_cells.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 12) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("** nearest_site_labeler: PASSED **");
        end else begin
            $display("** nearest_site_labeler: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/nsl_pkg.sv
rtl/core/nsl_cell.sv
rtl/core/nearest_site_labeler.sv
dv/nearest_site_labeler_test.sv
